FILE: rtl/icaf_pkg.sv
// Shared widths, register indexes, divisor constants and the CORDIC angle table.
`timescale 1ns / 1ps

package icaf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;
  localparam int CAL_W      = 17;
  localparam int STEP_W     = 10;
  localparam int GAIN_W     = 17;
  localparam int NUM_W      = 44;
  localparam int QUO_W      = NUM_W + 1;
  localparam int DEN_W      = 14;
  localparam int Z_W        = 27;
  localparam int CRD_W      = 40;
  localparam int CRD_FRAC   = 20;
  localparam int ANG_MAX    = 24;
  localparam int LUT_IDX_W  = $clog2(ANG_MAX);

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_OFS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFS_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN    = 3'd7;

  localparam logic [STEP_W-1:0] STEP_MS_RST  = 10'd20;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST = 17'd70779;

  localparam logic [DEN_W-1:0] DEN_GYRO  = 14'd1000;
  localparam logic [DEN_W-1:0] DEN_YAW   = 14'd16000;
  localparam logic [DEN_W-1:0] DEN_BLEND = 14'd50;

  localparam logic signed [Z_W-1:0] ANG_180 = 27'sd11796480;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/icaf_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in 1/65536 degree, one rotation per cycle.
`timescale 1ns / 1ps

module icaf_cordic #(
  parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [icaf_pkg::CAL_W-1:0]  y_i,
  input  logic signed [icaf_pkg::CAL_W-1:0]  x_i,
  output logic                               done_o,
  output logic signed [icaf_pkg::Z_W-1:0]    angle_o
);
  import icaf_pkg::*;

  localparam int STEPS_USED = (CORDIC_STEPS > ANG_MAX) ? ANG_MAX : CORDIC_STEPS;
  localparam logic [LUT_IDX_W-1:0] LAST_STEP = LUT_IDX_W'(STEPS_USED - 1);

  logic                    run_q;
  logic                    done_q;
  logic [LUT_IDX_W-1:0]    cnt_q;
  logic signed [CRD_W-1:0] x_q;
  logic signed [CRD_W-1:0] y_q;
  logic signed [Z_W-1:0]   z_q;

  logic signed [CRD_W-1:0] x_ext;
  logic signed [CRD_W-1:0] y_ext;
  logic signed [CRD_W-1:0] x_sh;
  logic signed [CRD_W-1:0] y_sh;
  logic                    zero_in;

  assign x_ext   = {{(CRD_W-CAL_W-CRD_FRAC){x_i[CAL_W-1]}}, x_i, {CRD_FRAC{1'b0}}};
  assign y_ext   = {{(CRD_W-CAL_W-CRD_FRAC){y_i[CAL_W-1]}}, y_i, {CRD_FRAC{1'b0}}};
  assign zero_in = (x_i == '0) && (y_i == '0);
  assign x_sh    = x_q >>> cnt_q;
  assign y_sh    = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= !zero_in;
      done_q <= zero_in;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (zero_in) begin
        x_q <= '0;
        y_q <= '0;
        z_q <= '0;
      end else if (x_i[CAL_W-1]) begin
        x_q <= -x_ext;
        y_q <= -y_ext;
        z_q <= y_i[CAL_W-1] ? -ANG_180 : ANG_180;
      end else begin
        x_q <= x_ext;
        y_q <= y_ext;
        z_q <= '0;
      end
    end else if (run_q) begin
      if (!y_q[CRD_W-1]) begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_lut(cnt_q);
      end else begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_lut(cnt_q);
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

FILE: rtl/icaf_div.sv
// Constant divider with round-half-away-from-zero: reciprocal multiply on 16-bit digits.
`timescale 1ns / 1ps

module icaf_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [icaf_pkg::NUM_W-1:0]  num_i,
  input  logic        [icaf_pkg::DEN_W-1:0]  den_i,
  output logic                               done_o,
  output logic signed [icaf_pkg::QUO_W-1:0]  quo_o
);
  import icaf_pkg::*;

  localparam int CHUNK_W = 16;
  localparam int NCHUNK  = (NUM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W   = NCHUNK * CHUNK_W;
  localparam int REM_W   = 7;
  localparam int T_W     = REM_W + CHUNK_W;
  localparam int RCP_W   = 24;
  localparam int PROD_W  = T_W + RCP_W;
  localparam int CNT_W   = $clog2(NCHUNK);
  localparam int SH_125  = 30;
  localparam int SH_25   = 28;

  localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCHUNK - 1);
  localparam logic [REM_W-1:0] DVS_125    = 7'd125;
  localparam logic [REM_W-1:0] DVS_25     = 7'd25;
  // ceil(2^30 / 125) and ceil(2^28 / 25), exact for digits below 2^23
  localparam logic [RCP_W-1:0] RCP_125    = 24'd8589935;
  localparam logic [RCP_W-1:0] RCP_25     = 24'd10737419;

  logic               run_q;
  logic               done_q;
  logic               ph_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;
  logic               sml_q;
  logic [PAD_W-1:0]   dq_q;
  logic [REM_W-1:0]   rem_q;
  logic [CHUNK_W-1:0] qc_q;

  logic [NUM_W-1:0]   mag;
  logic [NUM_W-1:0]   biased;
  logic [NUM_W-1:0]   scaled;
  logic               sml;
  logic [RCP_W-1:0]   rcp;
  logic [REM_W-1:0]   dvs;
  logic [T_W-1:0]     t;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] q;
  logic [T_W-1:0]     qd;
  logic [T_W-1:0]     rem_n;

  assign mag    = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign biased = mag + NUM_W'(den_i >> 1);

  // drop the power-of-two factor first: 1000, 16000 and 50 leave 125 or 25
  always_comb begin
    case (den_i)
      DEN_GYRO: begin
        scaled = biased >> 3;
        sml    = 1'b0;
      end
      DEN_YAW: begin
        scaled = biased >> 7;
        sml    = 1'b0;
      end
      DEN_BLEND: begin
        scaled = biased >> 1;
        sml    = 1'b1;
      end
      default: begin
        scaled = biased >> 3;
        sml    = 1'b0;
      end
    endcase
  end

  assign rcp   = sml_q ? RCP_25 : RCP_125;
  assign dvs   = sml_q ? DVS_25 : DVS_125;
  assign t     = {rem_q, dq_q[PAD_W-1 -: CHUNK_W]};
  assign prod  = PROD_W'(t) * PROD_W'(rcp);
  assign q     = sml_q ? prod[SH_25 +: CHUNK_W] : prod[SH_125 +: CHUNK_W];
  assign qd    = T_W'(qc_q) * T_W'(dvs);
  assign rem_n = t - qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      ph_q <= !ph_q;
      if (ph_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_CHUNK) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      sml_q <= sml;
      dq_q  <= PAD_W'(scaled);
      rem_q <= '0;
    end else if (run_q) begin
      if (!ph_q) begin
        qc_q <= q;
      end else begin
        rem_q <= rem_n[REM_W-1:0];
        dq_q  <= {dq_q[PAD_W-CHUNK_W-1:0], qc_q};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, dq_q[NUM_W-1:0]}) : $signed({1'b0, dq_q[NUM_W-1:0]});

endmodule

FILE: rtl/imu_complementary_attitude_filter.sv
// Top level: roll, pitch and yaw complementary attitude filter for six-axis IMU samples.
//
// One six-axis sample enters on the input valid/ready channel; one result with the
// filtered roll, pitch and yaw angles (1/65536 degree) leaves on the output channel.
// Offsets, the sample interval and the yaw gain are written through the register port;
// the user must write them only while the block is idle, as the block does not enforce it.
// An atan2 whose operands are both zero skips its rotations. in_ready_o is low from
// the transfer of a sample until its result is loaded into the output register, so a
// new sample is accepted only after the last one is through. The processing uses one
// iterative CORDIC (one rotation a cycle, run for roll then pitch) and one constant
// divider (reciprocal multiply on 16-bit digits, run five times).
// The output register holds the result until it is taken; a new sample is accepted
// and processed meanwhile, and its result waits until the output register is free.
// Reset clears the three angles, sets the registers to their defaults and drops
// any sample in progress.
`timescale 1ns / 1ps

module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [icaf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [icaf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [icaf_pkg::IN_W-1:0]       accel_x_i,
  input  logic signed [icaf_pkg::IN_W-1:0]       accel_y_i,
  input  logic signed [icaf_pkg::IN_W-1:0]       accel_z_i,
  input  logic signed [icaf_pkg::IN_W-1:0]       rate_x_i,
  input  logic signed [icaf_pkg::IN_W-1:0]       rate_y_i,
  input  logic signed [icaf_pkg::IN_W-1:0]       rate_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [icaf_pkg::OUT_W-1:0]      roll_out_o,
  output logic signed [icaf_pkg::OUT_W-1:0]      pitch_out_o,
  output logic signed [icaf_pkg::OUT_W-1:0]      yaw_out_o
);
  import icaf_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_ROLL_GO  = 4'd1;
  localparam logic [ST_W-1:0] ST_ROLL_WT  = 4'd2;
  localparam logic [ST_W-1:0] ST_PITCH_GO = 4'd3;
  localparam logic [ST_W-1:0] ST_PITCH_WT = 4'd4;
  localparam logic [ST_W-1:0] ST_MUL1     = 4'd5;
  localparam logic [ST_W-1:0] ST_MUL2     = 4'd6;
  localparam logic [ST_W-1:0] ST_INC_GO   = 4'd7;
  localparam logic [ST_W-1:0] ST_INC_WT   = 4'd8;
  localparam logic [ST_W-1:0] ST_BLD_GO   = 4'd9;
  localparam logic [ST_W-1:0] ST_BLD_WT   = 4'd10;
  localparam logic [ST_W-1:0] ST_OUT      = 4'd11;

  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  localparam int MA_W  = 27;
  localparam int MB_W  = 18;
  localparam int SUM_W = QUO_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic [ST_W-1:0] state_q, state_d;
  logic [1:0]      axis_q;
  logic            out_valid_q;

  logic signed [IN_W-1:0]   ofs_ax_q, ofs_ay_q, ofs_az_q;
  logic signed [IN_W-1:0]   ofs_gx_q, ofs_gy_q, ofs_gz_q;
  logic        [STEP_W-1:0] step_q;
  logic        [GAIN_W-1:0] gain_q;

  logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;
  logic signed [OUT_W-1:0] roll_out_q, pitch_out_q, yaw_out_q;

  logic signed [CAL_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic signed [Z_W-1:0]   acc_roll_q, acc_pitch_q;
  logic signed [NUM_W-1:0] prod_q;
  logic signed [OUT_W-1:0] sum_q;

  logic                    in_xfer;
  logic                    out_load;
  logic                    crd_start;
  logic signed [CAL_W-1:0] crd_y;
  logic                    crd_done;
  logic signed [Z_W-1:0]   crd_angle;
  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic        [DEN_W-1:0] div_den;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;

  logic signed [CAL_W-1:0] g_sel;
  logic signed [OUT_W-1:0] angle_sel;
  logic signed [Z_W-1:0]   acc_sel;
  logic                    yaw_pos;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MA_W+MB_W-1:0] mul_p;
  logic signed [NUM_W-1:0] sum_ext;
  logic signed [NUM_W-1:0] blend_num;
  logic signed [SUM_W-1:0] inc_sum;
  logic signed [SUM_W-1:0] quo_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (axis_q)
      AX_ROLL: begin
        g_sel     = gx_q;
        angle_sel = roll_q;
        acc_sel   = acc_roll_q;
      end
      AX_PITCH: begin
        g_sel     = gy_q;
        angle_sel = pitch_q;
        acc_sel   = acc_pitch_q;
      end
      default: begin
        g_sel     = gz_q;
        angle_sel = yaw_q;
        acc_sel   = acc_pitch_q;
      end
    endcase
  end

  assign yaw_pos = (axis_q == AX_YAW) && !gz_q[CAL_W-1];

  assign mul_a = (state_q == ST_MUL1) ? {{(MA_W-CAL_W){g_sel[CAL_W-1]}}, g_sel}
                                      : prod_q[MA_W-1:0];
  assign mul_b = (state_q == ST_MUL1) ? $signed({{(MB_W-STEP_W){1'b0}}, step_q})
                                      : (yaw_pos ? $signed({1'b0, gain_q}) : 18'sd4096);
  assign mul_p = mul_a * mul_b;

  assign sum_ext   = {{(NUM_W-OUT_W){sum_q[OUT_W-1]}}, sum_q};
  assign blend_num = (sum_ext <<< 5) + (sum_ext <<< 4) + sum_ext
                   + {{(NUM_W-Z_W){acc_sel[Z_W-1]}}, acc_sel};

  assign crd_start = (state_q == ST_ROLL_GO) || (state_q == ST_PITCH_GO);
  assign crd_y     = (state_q == ST_PITCH_GO) ? -ax_q : ay_q;

  assign div_start = (state_q == ST_INC_GO) || (state_q == ST_BLD_GO);
  assign div_num   = (state_q == ST_INC_GO) ? prod_q : blend_num;
  assign div_den   = (state_q == ST_INC_GO) ? (yaw_pos ? DEN_YAW : DEN_GYRO) : DEN_BLEND;

  assign quo_ext = {div_quo[QUO_W-1], div_quo};
  assign inc_sum = {{(SUM_W-OUT_W){angle_sel[OUT_W-1]}}, angle_sel} + quo_ext;

  icaf_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(crd_start),
    .y_i    (crd_y),
    .x_i    (az_q),
    .done_o (crd_done),
    .angle_o(crd_angle)
  );

  icaf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_ROLL_GO;
      ST_ROLL_GO:  state_d = ST_ROLL_WT;
      ST_ROLL_WT:  if (crd_done) state_d = ST_PITCH_GO;
      ST_PITCH_GO: state_d = ST_PITCH_WT;
      ST_PITCH_WT: if (crd_done) state_d = ST_MUL1;
      ST_MUL1:     state_d = ST_MUL2;
      ST_MUL2:     state_d = ST_INC_GO;
      ST_INC_GO:   state_d = ST_INC_WT;
      ST_INC_WT: begin
        if (div_done) state_d = (axis_q == AX_YAW) ? ST_OUT : ST_BLD_GO;
      end
      ST_BLD_GO:   state_d = ST_BLD_WT;
      ST_BLD_WT:   if (div_done) state_d = ST_MUL1;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AX_ROLL;
      out_valid_q <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      ofs_ax_q    <= '0;
      ofs_ay_q    <= '0;
      ofs_az_q    <= '0;
      ofs_gx_q    <= '0;
      ofs_gy_q    <= '0;
      ofs_gz_q    <= '0;
      step_q      <= STEP_MS_RST;
      gain_q      <= YAW_GAIN_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_OFS_X: ofs_ax_q <= cfg_data_i[IN_W-1:0];
          CFG_ACCEL_OFS_Y: ofs_ay_q <= cfg_data_i[IN_W-1:0];
          CFG_ACCEL_OFS_Z: ofs_az_q <= cfg_data_i[IN_W-1:0];
          CFG_GYRO_OFS_X:  ofs_gx_q <= cfg_data_i[IN_W-1:0];
          CFG_GYRO_OFS_Y:  ofs_gy_q <= cfg_data_i[IN_W-1:0];
          CFG_GYRO_OFS_Z:  ofs_gz_q <= cfg_data_i[IN_W-1:0];
          CFG_STEP_MS:     step_q   <= cfg_data_i[STEP_W-1:0];
          CFG_YAW_GAIN:    gain_q   <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        axis_q <= AX_ROLL;
      end else if ((state_q == ST_BLD_WT) && div_done) begin
        axis_q <= axis_q + 1'b1;
      end
      if ((state_q == ST_INC_WT) && div_done && (axis_q == AX_YAW)) begin
        yaw_q <= sat32(inc_sum);
      end
      if ((state_q == ST_BLD_WT) && div_done) begin
        if (axis_q == AX_ROLL) begin
          roll_q <= sat32(quo_ext);
        end else begin
          pitch_q <= sat32(quo_ext);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ax_q <= CAL_W'(accel_x_i) - CAL_W'(ofs_ax_q);
      ay_q <= CAL_W'(accel_y_i) - CAL_W'(ofs_ay_q);
      az_q <= CAL_W'(accel_z_i) - CAL_W'(ofs_az_q);
      gx_q <= CAL_W'(rate_x_i) - CAL_W'(ofs_gx_q);
      gy_q <= CAL_W'(rate_y_i) - CAL_W'(ofs_gy_q);
      gz_q <= CAL_W'(rate_z_i) - CAL_W'(ofs_gz_q);
    end
    if ((state_q == ST_ROLL_WT) && crd_done) begin
      acc_roll_q <= crd_angle;
    end
    if ((state_q == ST_PITCH_WT) && crd_done) begin
      acc_pitch_q <= crd_angle;
    end
    if ((state_q == ST_MUL1) || (state_q == ST_MUL2)) begin
      prod_q <= mul_p[NUM_W-1:0];
    end
    if ((state_q == ST_INC_WT) && div_done) begin
      sum_q <= sat32(inc_sum);
    end
    if (out_load) begin
      roll_out_q  <= roll_q;
      pitch_out_q <= pitch_q;
      yaw_out_q   <= yaw_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_out_o  = roll_out_q;
  assign pitch_out_o = pitch_out_q;
  assign yaw_out_o   = yaw_out_q;

endmodule

FILE: tb/tb_top.sv
// Testbench for the complementary attitude filter: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import icaf_pkg::*;

  localparam int CORDIC_N  = CORDIC_STEPS_DEF;
  localparam int ROT_STEPS = (CORDIC_N > ANG_MAX) ? ANG_MAX : CORDIC_N;
  localparam int LATENCY   = 2 * CORDIC_N + 241;
  localparam int RX_PARK   = 1200;

  typedef struct packed {
    logic signed [IN_W-1:0] ax, ay, az, gx, gy, gz;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] roll, pitch, yaw;
  } attitude_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [IN_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [IN_W-1:0] rate_x = '0, rate_y = '0, rate_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [OUT_W-1:0] roll_out, pitch_out, yaw_out;

  // predictor state and register copy
  longint roll_st = 0, pitch_st = 0, yaw_st = 0;
  logic signed [IN_W-1:0] ofs_tbl [6] = '{default: '0};
  logic [STEP_W-1:0] step_ms_cfg = STEP_MS_RST;
  logic [GAIN_W-1:0] yaw_gain_cfg = YAW_GAIN_RST;
  longint atan_tbl [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  sample_t   sample_q [$];
  attitude_t attitude_q [$];
  sample_t   cur_sample;
  attitude_t want;
  int        n_queued = 0;
  int        n_taken = 0;
  int        n_bad = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      calm = 1'b0;
  logic      park_rx = 1'b0;
  logic      park_go = 1'b0;

  imu_complementary_attitude_filter #(
    .CORDIC_STEPS(CORDIC_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .accel_x_i  (accel_x),
    .accel_y_i  (accel_y),
    .accel_z_i  (accel_z),
    .rate_x_i   (rate_x),
    .rate_y_i   (rate_y),
    .rate_z_i   (rate_z),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .roll_out_o (roll_out),
    .pitch_out_o(pitch_out),
    .yaw_out_o  (yaw_out)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint round_div(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tilt_angle(input longint y, input longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 1048576;
    y = y * 1048576;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_tbl[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_tbl[i];
      end
    end
    return z;
  endfunction

  function automatic attitude_t predict_attitude(input sample_t s);
    longint ax, ay, az, gx, gy, gz, dt, gain, acc_roll, acc_pitch, sr, sp, inc;
    attitude_t r;
    ax = longint'(s.ax) - longint'(ofs_tbl[CFG_ACCEL_OFS_X]);
    ay = longint'(s.ay) - longint'(ofs_tbl[CFG_ACCEL_OFS_Y]);
    az = longint'(s.az) - longint'(ofs_tbl[CFG_ACCEL_OFS_Z]);
    gx = longint'(s.gx) - longint'(ofs_tbl[CFG_GYRO_OFS_X]);
    gy = longint'(s.gy) - longint'(ofs_tbl[CFG_GYRO_OFS_Y]);
    gz = longint'(s.gz) - longint'(ofs_tbl[CFG_GYRO_OFS_Z]);
    dt = longint'(step_ms_cfg);
    gain = longint'(yaw_gain_cfg);
    acc_roll = tilt_angle(ay, az);
    acc_pitch = tilt_angle(-ax, az);
    sr = clamp32(roll_st + round_div(gx * dt * 4096, 1000));
    sp = clamp32(pitch_st + round_div(gy * dt * 4096, 1000));
    if (gz < 0) inc = round_div(gz * dt * 4096, 1000);
    else inc = round_div(gz * dt * gain, 16000);
    yaw_st = clamp32(yaw_st + inc);
    roll_st = clamp32(round_div(49 * sr + acc_roll, 50));
    pitch_st = clamp32(round_div(49 * sp + acc_pitch, 50));
    r.roll = roll_st[31:0];
    r.pitch = pitch_st[31:0];
    r.yaw = yaw_st[31:0];
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_field(input logic signed [IN_W-1:0] ofs);
    logic signed [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = ofs;
      1: v = 16'sh7FFF;
      2: v = 16'sh8000;
      3: v = ofs + 16'($urandom_range(0, 128)) - 16'sd64;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_sample(input logic signed [IN_W-1:0] ax, ay, az, gx, gy, gz);
    sample_t s;
    s = '{ax, ay, az, gx, gy, gz};
    sample_q.push_back(s);
    n_queued++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      queue_sample(pick_field(ofs_tbl[CFG_ACCEL_OFS_X]), pick_field(ofs_tbl[CFG_ACCEL_OFS_Y]),
                   pick_field(ofs_tbl[CFG_ACCEL_OFS_Z]), pick_field(ofs_tbl[CFG_GYRO_OFS_X]),
                   pick_field(ofs_tbl[CFG_GYRO_OFS_Y]), pick_field(ofs_tbl[CFG_GYRO_OFS_Z]));
    end
  endtask

  task automatic drain();
    while (n_queued != n_taken || attitude_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == CFG_STEP_MS) step_ms_cfg = val[STEP_W-1:0];
    else if (idx == CFG_YAW_GAIN) yaw_gain_cfg = val[GAIN_W-1:0];
    else ofs_tbl[idx] = val[IN_W-1:0];
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] ofs_a, ofs_g, step, gain);
    write_reg(CFG_ACCEL_OFS_X, ofs_a);
    write_reg(CFG_ACCEL_OFS_Y, ofs_a);
    write_reg(CFG_ACCEL_OFS_Z, ofs_a);
    write_reg(CFG_GYRO_OFS_X, ofs_g);
    write_reg(CFG_GYRO_OFS_Y, ofs_g);
    write_reg(CFG_GYRO_OFS_Z, ofs_g);
    write_reg(CFG_STEP_MS, step);
    write_reg(CFG_YAW_GAIN, gain);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(CFG_ACCEL_OFS_X, 17'($urandom));
    write_reg(CFG_ACCEL_OFS_Y, 17'($urandom));
    write_reg(CFG_ACCEL_OFS_Z, 17'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2048)));
    write_reg(CFG_GYRO_OFS_X, 17'($urandom));
    write_reg(CFG_GYRO_OFS_Y, 17'($urandom));
    write_reg(CFG_GYRO_OFS_Z, 17'($urandom));
    write_reg(CFG_STEP_MS, 17'($urandom_range(1, 1000)));
    write_reg(CFG_YAW_GAIN, 17'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        attitude_q.push_back(predict_attitude(cur_sample));
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_sample = sample_q.pop_front();
          accel_x <= cur_sample.ax;
          accel_y <= cur_sample.ay;
          accel_z <= cur_sample.az;
          rate_x <= cur_sample.gx;
          rate_y <= cur_sample.gy;
          rate_z <= cur_sample.gz;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (attitude_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected transfer: roll %0d pitch %0d yaw %0d",
                     roll_out, pitch_out, yaw_out);
        end else begin
          want = attitude_q.pop_front();
          if (roll_out !== want.roll || pitch_out !== want.pitch || yaw_out !== want.yaw) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                       want.roll, roll_out, want.pitch, pitch_out, want.yaw, yaw_out);
          end
        end
      end
      if (park_rx) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) rx_gap <= $urandom_range(1, 18);
      end
    end
  end

  // hold the receiver off so the block backs up into its input
  initial begin
    wait (park_go);
    @(posedge clk_i);
    park_rx <= 1'b1;
    repeat (RX_PARK) @(posedge clk_i);
    park_rx <= 1'b0;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults
    queue_sample(0, 0, 0, 0, 0, 0);
    queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(0, 0, 16384, 0, 0, 0);
    queue_sample(16384, 0, 0, 0, 0, 0);
    queue_sample(-16384, 0, 0, 0, 0, 0);
    queue_sample(0, 0, -16384, 0, 0, 0);
    queue_sample(0, 100, -16384, 0, 0, 0);
    queue_sample(0, -100, -16384, 0, 0, 0);
    queue_sample(100, 0, -16384, 0, 0, 0);
    queue_sample(0, 16384, 0, 0, 0, 0);
    queue_sample(0, -16384, 0, 0, 0, 0);
    queue_sample(0, 0, 16384, 0, 0, -1);
    queue_sample(0, 0, 16384, 0, 0, 1);
    queue_sample(0, 0, 16384, 0, 0, 16'sh7FFF);
    queue_sample(0, 0, 16384, 0, 0, 16'sh8000);
    queue_sample(0, 0, 16384, 16'sh7FFF, 16'sh8000, 0);
    queue_sample(0, 0, 16384, 16'sh8000, 16'sh7FFF, 0);
    queue_random(200);
    drain();

    // step 1000, full gain: drive the angles into saturation
    set_config(17'h0, 17'h0, 17'd1000, 17'h1FFFF);
    repeat (12) queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    repeat (12) queue_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_random(200);
    drain();

    // largest offsets, step beyond 1000, zero positive yaw gain
    set_config(17'h07FFF, 17'h07FFF, 17'd1023, 17'd0);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_random(250);
    park_go = 1'b1;
    drain();

    // smallest offsets, step zero freezes integration
    set_config(17'h18000, 17'h08000, 17'd0, 17'd1);
    queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_random(150);
    drain();

    set_config(17'h0, 17'h0, 17'd1, 17'd65536);
    queue_random(150);
    drain();

    repeat (4) begin
      random_config();
      queue_random(220);
      drain();
    end

    @(posedge clk_i);
    calm <= 1'b1;
    random_config();
    queue_random(200);
    drain();

    repeat (LATENCY + 30) @(posedge clk_i);
    if (n_bad == 0 && attitude_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
